// ===== src/pdru_pkg.sv =====
package pdru_pkg;

    localparam int NUM_SLOTS  = 4;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_W     = 4;

    localparam int FACE_W  = 16;
    localparam int TS_W    = 64;
    localparam int TOKEN_W = 64;
    localparam int NONCE_W = 32;
    localparam int LIFE_W  = 32;
    localparam int TPS_W   = 34;
    localparam int CNT_W   = 8;

    localparam int S_DATA_W = 216;
    localparam int M_DATA_W = 72;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 34;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIFETIME  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 1'b1;

    localparam logic [LIFE_W-1:0] MAX_LIFETIME_RST  = 32'd120000;
    localparam logic [TPS_W-1:0]  TICKS_PER_SEC_RST = 34'd1000000000;

    // long division of the 66-bit product by 1000, one byte per cycle
    localparam int PROD_W     = LIFE_W + TPS_W;
    localparam int DIV_STEP_W = 8;
    localparam int DIV_STEPS  = (PROD_W + DIV_STEP_W - 1) / DIV_STEP_W;
    localparam int DIV_W      = DIV_STEPS * DIV_STEP_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int REM_W      = 10;
    localparam logic [REM_W:0] MS_PER_SEC = 11'd1000;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic fail;
        logic mul;
        logic sum;
        logic div_step;
        logic add;
        logic commit;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic scan_hit;
        logic scan_last;
        logic div_last;
        logic out_busy;
    } sts_t;

endpackage

// ===== src/pit_downstream_record_update.sv =====
// Downstream record keeper for one pending-interest entry.
// Slave stream (s_*): one beat per interest; s_tuser carries the new-entry
// flag, s_tdata the face, timestamp, token, prefix flag, nonce and lifetime.
// Master stream (m_*): one beat per interest with ok, slot index, replace and
// drop flags, reschedule flag and the entry expiry after the update.
// Config port: cfg_we writes cfg_data to register cfg_index (0 max lifetime
// in ms, 1 ticks per second); write only while no interest is in flight.
// One interest is handled at a time. The slot scan checks one slot per cycle;
// a taken slot then goes through a multiply, a sum, the byte-per-cycle
// divide by 1000, an add and an update step. A rejected interest scans all
// four slots. The result sits in an output register; a stalled m_tready
// holds the next finished result inside until the register frees.
// s_tready is high only while the block is idle.
// Reset clears all slot valid bits, the prefix count and the entry expiry,
// and loads the default configuration.
module pit_downstream_record_update (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pdru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pdru_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] face, [79:16] timestamp, [143:80] pit_token, [144] can_be_prefix,
    // [176:145] nonce, [208:177] lifetime_ms, [215:209] zero
    input  logic [pdru_pkg::S_DATA_W-1:0]     s_tdata,
    // [0] new_entry
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] ok, [4:1] slot, [5] replace_representative, [6] drop_packet,
    // [7] reschedule, [71:8] entry_expiry
    output logic [pdru_pkg::M_DATA_W-1:0]     m_tdata
);
    import pdru_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pdru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pdru_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== src/pdru_ctrl.sv =====
module pdru_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  pdru_pkg::sts_t sts,
    output pdru_pkg::cmd_t cmd
);
    import pdru_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_ADD,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = ST_MUL;
                end
                else if (sts.scan_last)
                begin
                    cmd.fail   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/pdru_dp.sv =====
module pdru_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pdru_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pdru_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [pdru_pkg::S_DATA_W-1:0]         s_tdata,
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pdru_pkg::M_DATA_W-1:0]         m_tdata,
    input  pdru_pkg::cmd_t                        cmd,
    output pdru_pkg::sts_t                        sts
);
    import pdru_pkg::*;

    // configuration
    logic [LIFE_W-1:0] max_life_reg;
    logic [TPS_W-1:0]  tps_reg;

    // item
    logic               new_reg;
    logic [FACE_W-1:0]  face_reg;
    logic [TS_W-1:0]    ts_reg;
    logic [TOKEN_W-1:0] token_reg;
    logic               cbp_reg;
    logic [NONCE_W-1:0] nonce_reg;
    logic [LIFE_W-1:0]  life_reg;

    logic [FACE_W-1:0]  in_face;
    logic [TS_W-1:0]    in_ts;
    logic [TOKEN_W-1:0] in_token;
    logic               in_cbp;
    logic [NONCE_W-1:0] in_nonce;
    logic [LIFE_W-1:0]  in_life;

    // slot store
    logic [NUM_SLOTS-1:0] slot_valid_reg;
    logic [FACE_W-1:0]    slot_face_reg   [NUM_SLOTS];
    logic [TS_W-1:0]      slot_expiry_reg [NUM_SLOTS];
    logic                 slot_prefix_reg [NUM_SLOTS];
    logic [TOKEN_W-1:0]   slot_token_reg  [NUM_SLOTS];
    logic [NONCE_W-1:0]   slot_nonce_reg  [NUM_SLOTS];

    logic [CNT_W-1:0]  prefix_cnt_reg;
    logic [TS_W-1:0]   entry_exp_reg;
    logic [SLOT_W-1:0] last_slot_reg;

    // scan
    logic [SLOT_IDX_W-1:0] scan_reg;
    logic                  slot_free;
    logic                  slot_match;
    logic                  slot_expired;

    // expiry arithmetic
    logic [TS_W-1:0]         p_lo_reg;
    logic [LIFE_W+1:0]       p_hi_reg;
    logic [DIV_W-1:0]        div_reg;
    logic [DIV_W-1:0]        div_next;
    logic [REM_W-1:0]        rem_reg;
    logic [REM_W-1:0]        rem_next;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic [TS_W-1:0]         exp_reg;

    // update
    logic [CNT_W-1:0] cnt_base;
    logic [TS_W-1:0]  entry_base;
    logic             raise;

    // result
    logic res_ok_reg;
    logic res_repl_reg;
    logic res_drop_reg;
    logic res_resched_reg;
    logic m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    assign in_face  = s_tdata[15:0];
    assign in_ts    = s_tdata[79:16];
    assign in_token = s_tdata[143:80];
    assign in_cbp   = s_tdata[144];
    assign in_nonce = s_tdata[176:145];
    assign in_life  = s_tdata[208:177];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_life_reg <= MAX_LIFETIME_RST;
            tps_reg      <= TICKS_PER_SEC_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_LIFETIME:  max_life_reg <= cfg_data[LIFE_W-1:0];
                CFG_TICKS_PER_SEC: tps_reg      <= cfg_data[TPS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            new_reg   <= s_tuser;
            face_reg  <= in_face;
            ts_reg    <= in_ts;
            token_reg <= in_token;
            cbp_reg   <= in_cbp;
            nonce_reg <= in_nonce;
            life_reg  <= (in_life > max_life_reg) ? max_life_reg : in_life;
        end
    end

    // scan one slot per cycle
    assign slot_free    = !slot_valid_reg[scan_reg];
    assign slot_match   = slot_face_reg[scan_reg] == face_reg;
    assign slot_expired = slot_expiry_reg[scan_reg] < ts_reg;

    assign sts.scan_hit  = new_reg || slot_free || slot_match || slot_expired;
    assign sts.scan_last = scan_reg == SLOT_IDX_W'(NUM_SLOTS - 1);
    assign sts.div_last  = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign sts.out_busy  = m_tvalid_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else if (cmd.load)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_step && !sts.scan_hit && !sts.scan_last)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
    end

    // restoring division by 1000, a byte of the dividend per cycle
    always_comb
    begin
        logic [REM_W:0]        t;
        logic [REM_W-1:0]      r;
        logic [DIV_STEP_W-1:0] q;
        r = rem_reg;
        q = '0;
        for (int k = 0; k < DIV_STEP_W; k++)
        begin
            t = {r, div_reg[DIV_W-1-k]};
            if (t >= MS_PER_SEC)
            begin
                t = t - MS_PER_SEC;
                q[DIV_STEP_W-1-k] = 1'b1;
            end
            r = t[REM_W-1:0];
        end
        rem_next = r;
        div_next = {div_reg[DIV_W-DIV_STEP_W-1:0], q};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            p_lo_reg <= life_reg * tps_reg[31:0];
            p_hi_reg <= life_reg * tps_reg[TPS_W-1:32];
        end
        if (cmd.sum)
        begin
            div_reg <= DIV_W'({2'b00, p_lo_reg}) + DIV_W'({p_hi_reg, 32'd0});
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_next;
            rem_reg <= rem_next;
        end
        if (cmd.add)
        begin
            exp_reg <= ts_reg + div_reg[TS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.sum)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    assign cnt_base   = new_reg ? '0 : prefix_cnt_reg;
    assign entry_base = new_reg ? '0 : entry_exp_reg;
    assign raise      = exp_reg > entry_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg  <= '0;
            prefix_cnt_reg  <= '0;
            entry_exp_reg   <= '0;
            last_slot_reg   <= '0;
            res_ok_reg      <= 1'b0;
            res_repl_reg    <= 1'b0;
            res_drop_reg    <= 1'b0;
            res_resched_reg <= 1'b0;
        end
        else
        begin
            // an expired slot returns its prefix flag before reuse
            if (cmd.scan_step && !new_reg && !slot_free && !slot_match && slot_expired)
            begin
                prefix_cnt_reg <= prefix_cnt_reg - CNT_W'(slot_prefix_reg[scan_reg]);
            end
            if (cmd.fail)
            begin
                res_ok_reg      <= 1'b0;
                res_repl_reg    <= 1'b0;
                res_drop_reg    <= 1'b0;
                res_resched_reg <= 1'b0;
            end
            if (cmd.commit)
            begin
                slot_valid_reg  <= (new_reg ? {NUM_SLOTS{1'b0}} : slot_valid_reg)
                                   | (NUM_SLOTS'(1) << scan_reg);
                prefix_cnt_reg  <= cnt_base + CNT_W'(cbp_reg);
                entry_exp_reg   <= raise ? exp_reg : entry_base;
                last_slot_reg   <= SLOT_W'(scan_reg);
                res_ok_reg      <= 1'b1;
                res_repl_reg    <= !new_reg && (cnt_base != CNT_W'(cbp_reg));
                res_drop_reg    <= !new_reg && (cnt_base == CNT_W'(cbp_reg));
                res_resched_reg <= raise;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            slot_face_reg[scan_reg]   <= face_reg;
            slot_expiry_reg[scan_reg] <= exp_reg;
            slot_prefix_reg[scan_reg] <= cbp_reg;
            slot_token_reg[scan_reg]  <= token_reg;
            slot_nonce_reg[scan_reg]  <= nonce_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_tdata_reg <= {entry_exp_reg, res_resched_reg, res_drop_reg, res_repl_reg,
                            res_ok_reg ? last_slot_reg : SLOT_W'(0), res_ok_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
